### rtl/fdtd_pkg.sv
package fdtd_pkg;

	// grid size default
	localparam int CELLS_DEF = 2048;

	// field and coefficient widths
	localparam int VAL_W     = 32;
	localparam int COEF_W    = 40;
	localparam int IDX_W     = 11;
	localparam int REG_IDX_W = 2;

	// multiply-shift datapath widths
	localparam int DIFF_W = VAL_W + 1;
	localparam int HALF_W = COEF_W / 2;
	localparam int PROD_W = DIFF_W + HALF_W + 1;
	localparam int SUM_W  = PROD_W + HALF_W;
	localparam int FRAC   = 24;
	localparam int Q_W    = SUM_W - FRAC;
	localparam int ACC_W  = Q_W + 2;

	// register reset values
	localparam logic [COEF_W-1:0] E_COEF_RST = 40'd6320485838;
	localparam logic [COEF_W-1:0] H_COEF_RST = 40'd44534;
	localparam logic [IDX_W-1:0]  SOURCE_RST = 11'd500;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [COEF_W-1:0]       coef_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_E_COEF = 2'd0,
		REG_H_COEF = 2'd1,
		REG_SOURCE = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	// what an issued element does in the pipeline
	typedef enum logic [1:0] {
		K_CELL  = 2'd0,
		K_GAUSS = 2'd1,
		K_READ  = 2'd2
	} kind_t;

	typedef enum logic {
		PH_H = 1'b0,
		PH_E = 1'b1
	} phase_t;

	// control word from the sequencer to the datapath
	typedef struct packed {
		logic   valid;
		logic   clear;
		kind_t  kind;
		phase_t phase;
		logic   zero_d;
		logic   fix;
		logic   oob;
	} issue_t;

	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32'sh7fffffff);
	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(32'sh80000000);

	// saturate a wide signed sum to the cell range
	function automatic val_t sat32(input logic signed [ACC_W-1:0] v);
		val_t r;
		if (v > ACC_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < ACC_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/fdtd_in_if.sv
interface fdtd_in_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	fdtd_pkg::val_t               gauss_value;
	fdtd_pkg::val_t               sine_value;
	logic [fdtd_pkg::IDX_W-1:0]   cell_index;

	modport source (
		output valid, opcode, gauss_value, sine_value, cell_index,
		input  ready
	);
	modport sink (
		input  valid, opcode, gauss_value, sine_value, cell_index,
		output ready
	);
endinterface

### rtl/fdtd_out_if.sv
interface fdtd_out_if;
	logic           valid;
	logic           ready;
	fdtd_pkg::val_t e_sample;
	fdtd_pkg::val_t h_sample;

	modport source (
		output valid, e_sample, h_sample,
		input  ready
	);
	modport sink (
		input  valid, e_sample, h_sample,
		output ready
	);
endinterface

### rtl/fdtd_mac.sv
module fdtd_mac (
	input  logic                                 clk,
	input  logic signed [fdtd_pkg::DIFF_W-1:0]   d,
	input  fdtd_pkg::coef_t                      coef,
	output logic signed [fdtd_pkg::Q_W-1:0]      q
);
	import fdtd_pkg::*;

	logic signed [HALF_W:0]   hi;
	logic signed [HALF_W:0]   lo;
	logic signed [PROD_W-1:0] pa_s3;
	logic signed [PROD_W-1:0] pb_s3;
	logic signed [SUM_W-1:0]  sum;
	logic signed [Q_W-1:0]    q_s4;

	// coefficient split into two unsigned halves
	assign hi = {1'b0, coef[COEF_W-1:HALF_W]};
	assign lo = {1'b0, coef[HALF_W-1:0]};

	// recombine partial products, arithmetic shift floors toward minus infinity
	assign sum = (SUM_W'(pa_s3) <<< HALF_W) + SUM_W'(pb_s3);

	always_ff @(posedge clk) begin
		pa_s3 <= d * hi;
		pb_s3 <= d * lo;
		q_s4  <= Q_W'(sum >>> FRAC);
	end

	assign q = q_s4;
endmodule

### rtl/fdtd_core.sv
module fdtd_core #(
	parameter int CELLS = fdtd_pkg::CELLS_DEF,
	localparam int AW = $clog2(CELLS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fdtd_pkg::issue_t op,
	input  logic [AW-1:0]    m_addr,
	input  logic [AW-1:0]    nb_addr,
	input  logic [AW-1:0]    old_addr,
	input  fdtd_pkg::val_t   gauss,
	input  fdtd_pkg::val_t   sine,
	input  fdtd_pkg::coef_t  e_coef,
	input  fdtd_pkg::coef_t  h_coef,
	output logic             res_valid,
	output fdtd_pkg::val_t   res_e,
	output fdtd_pkg::val_t   res_h,
	output logic             busy,
	output logic             upd_busy
);
	import fdtd_pkg::*;

	val_t e_mem [CELLS];
	val_t h_mem [CELLS];

	logic [AW-1:0] e_ra, e_rb, h_ra, h_rb, wa;
	val_t          e_da_s1, e_db_s1, h_da_s1, h_db_s1;
	logic          e_we, h_we;
	val_t          wdata;

	issue_t op_in;
	issue_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [AW-1:0] addr_s1, addr_s2, addr_s3, addr_s4, addr_s5;

	logic signed [DIFF_W-1:0] d_s1, d_s2;
	val_t                     old_s1, old_s2, old_s3, old_s4;
	coef_t                    coef_s2;
	logic signed [Q_W-1:0]    q_s4, g_q;
	val_t                     t1_s4, t1_s5, w_val;
	logic                     upd_s5;

	// read ports: the neighbor field for the difference, the own field for the old value
	always_comb begin
		if (op.phase == PH_H) begin
			e_ra = m_addr;
			h_ra = old_addr;
		end else begin
			e_ra = old_addr;
			h_ra = m_addr;
		end
		e_rb = nb_addr;
		h_rb = nb_addr;
	end

	// write port: clearing pass or the last stage
	assign upd_s5 = ctl_s5.valid && (ctl_s5.kind == K_CELL);
	assign wa     = op.clear ? m_addr : addr_s5;
	assign wdata  = op.clear ? '0 : w_val;
	assign e_we   = (op.valid && op.clear) || (upd_s5 && ctl_s5.phase == PH_E);
	assign h_we   = (op.valid && op.clear) || (upd_s5 && ctl_s5.phase == PH_H);

	always_ff @(posedge clk) begin
		if (e_we) begin
			e_mem[wa] <= wdata;
		end
		e_da_s1 <= e_mem[e_ra];
		e_db_s1 <= e_mem[e_rb];
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			h_mem[wa] <= wdata;
		end
		h_da_s1 <= h_mem[h_ra];
		h_db_s1 <= h_mem[h_rb];
	end

	// read request result
	assign res_valid = ctl_s1.valid && (ctl_s1.kind == K_READ);
	assign res_e     = ctl_s1.oob ? '0 : e_da_s1;
	assign res_h     = ctl_s1.oob ? '0 : h_da_s1;

	// field difference and old cell value
	always_comb begin
		if (ctl_s1.zero_d) begin
			d_s1 = '0;
		end else if (ctl_s1.kind == K_GAUSS) begin
			d_s1 = DIFF_W'(gauss);
		end else if (ctl_s1.phase == PH_H) begin
			d_s1 = DIFF_W'(e_db_s1) - DIFF_W'(e_da_s1);
		end else begin
			d_s1 = DIFF_W'(h_da_s1) - DIFF_W'(h_db_s1);
		end
		old_s1 = (ctl_s1.phase == PH_H) ? h_da_s1 : e_da_s1;
	end

	// coefficient for this element
	assign coef_s2 = (ctl_s2.kind == K_GAUSS || ctl_s2.phase == PH_H) ? h_coef : e_coef;

	fdtd_mac u_mac (
		.clk  (clk),
		.d    (d_s2),
		.coef (coef_s2),
		.q    (q_s4)
	);

	// cell plus increment
	assign t1_s4 = sat32(ACC_W'(old_s4) + ACC_W'(q_s4));

	// source terms on the cell before the source (h) and at the source (e)
	always_comb begin
		if (ctl_s5.fix) begin
			if (ctl_s5.phase == PH_H) begin
				w_val = sat32(ACC_W'(t1_s5) - ACC_W'(g_q));
			end else begin
				w_val = sat32(ACC_W'(t1_s5) + ACC_W'(sine));
			end
		end else begin
			w_val = t1_s5;
		end
	end

	// issue word entering the pipeline, clearing writes carry no element
	always_comb begin
		op_in       = op;
		op_in.valid = op.valid && !op.clear;
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s1 <= op_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		addr_s1 <= m_addr;
		addr_s2 <= addr_s1;
		addr_s3 <= addr_s2;
		addr_s4 <= addr_s3;
		addr_s5 <= addr_s4;
		d_s2    <= d_s1;
		old_s2  <= old_s1;
		old_s3  <= old_s2;
		old_s4  <= old_s3;
		t1_s5   <= t1_s4;
		if (ctl_s4.valid && ctl_s4.kind == K_GAUSS) begin
			g_q <= q_s4;
		end
	end

	assign busy = ctl_s1.valid || ctl_s2.valid || ctl_s3.valid || ctl_s4.valid
		|| ctl_s5.valid;
	assign upd_busy = (ctl_s1.valid && ctl_s1.kind != K_READ)
		|| (ctl_s2.valid && ctl_s2.kind != K_READ)
		|| (ctl_s3.valid && ctl_s3.kind != K_READ)
		|| (ctl_s4.valid && ctl_s4.kind != K_READ)
		|| (ctl_s5.valid && ctl_s5.kind != K_READ);
endmodule

### rtl/fdtd_seq.sv
module fdtd_seq #(
	parameter int CELLS = fdtd_pkg::CELLS_DEF,
	localparam int AW = $clog2(CELLS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       opcode,
	input  fdtd_pkg::val_t             gauss_value,
	input  fdtd_pkg::val_t             sine_value,
	input  logic [fdtd_pkg::IDX_W-1:0] cell_index,
	input  logic [fdtd_pkg::IDX_W-1:0] source_cell,
	input  logic                       out_free,
	input  logic                       core_busy,
	output logic                       ready,
	output fdtd_pkg::issue_t           op,
	output logic [AW-1:0]              m_addr,
	output logic [AW-1:0]              nb_addr,
	output logic [AW-1:0]              old_addr,
	output fdtd_pkg::val_t             gauss,
	output fdtd_pkg::val_t             sine
);
	import fdtd_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_GAUSS  = 8'b0000_0100,
		S_HSWEEP = 8'b0000_1000,
		S_HDRAIN = 8'b0001_0000,
		S_ESWEEP = 8'b0010_0000,
		S_EDRAIN = 8'b0100_0000,
		S_READ   = 8'b1000_0000
	} seq_state_t;

	localparam logic [AW-1:0] LAST     = AW'(CELLS - 1);
	localparam logic [AW-1:0] PEN      = AW'(CELLS - 2);
	localparam logic [AW-1:0] ONE_ADDR = AW'(1);

	seq_state_t state_q, state_n;
	logic [AW-1:0] cnt_q, cnt_n;
	issue_t op_q, op_n;
	logic [AW-1:0] m_q, nb_q, old_q, m_n, nb_n, old_n;
	val_t gauss_q, sine_q;
	logic [IDX_W-1:0] idx_q;

	logic cnt_last, cnt_zero, src_in, h_src_ok, busy_all;
	logic [AW-1:0] src_addr, idx_addr;

	assign cnt_last = (cnt_q == LAST);
	assign cnt_zero = (cnt_q == '0);
	assign src_in   = 32'(source_cell) < 32'(CELLS);
	assign h_src_ok = src_in && (source_cell != '0);
	assign src_addr = AW'(source_cell);
	assign idx_addr = AW'(idx_q);
	assign busy_all = op_q.valid || core_busy;

	// next state and element to issue
	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		op_n    = '0;
		m_n     = cnt_q;
		nb_n    = cnt_q;
		old_n   = cnt_q;
		case (state_q)
			S_CLEAR: begin
				op_n.valid = 1'b1;
				op_n.clear = 1'b1;
				if (cnt_last) begin
					cnt_n   = '0;
					state_n = S_IDLE;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_n = (opcode == OP_READ) ? S_READ : S_GAUSS;
				end
			end
			S_GAUSS: begin
				op_n.valid = 1'b1;
				op_n.kind  = K_GAUSS;
				op_n.phase = PH_H;
				cnt_n      = '0;
				state_n    = S_HSWEEP;
			end
			S_HSWEEP: begin
				// last element copies its neighbor; the read beats the neighbor's write
				op_n.valid  = 1'b1;
				op_n.kind   = K_CELL;
				op_n.phase  = PH_H;
				op_n.zero_d = cnt_last;
				op_n.fix    = h_src_ok && (cnt_q == src_addr - 1'b1);
				nb_n        = cnt_last ? '0 : cnt_q + 1'b1;
				old_n       = cnt_last ? PEN : cnt_q;
				if (cnt_last) begin
					cnt_n   = '0;
					state_n = S_HDRAIN;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			S_HDRAIN: begin
				if (!busy_all) begin
					state_n = S_ESWEEP;
				end
			end
			S_ESWEEP: begin
				// first element copies its neighbor before that one is updated
				op_n.valid  = 1'b1;
				op_n.kind   = K_CELL;
				op_n.phase  = PH_E;
				op_n.zero_d = cnt_zero;
				op_n.fix    = src_in && (cnt_q == src_addr);
				nb_n        = cnt_zero ? '0 : cnt_q - 1'b1;
				old_n       = cnt_zero ? ONE_ADDR : cnt_q;
				if (cnt_last) begin
					cnt_n   = '0;
					state_n = S_EDRAIN;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			S_EDRAIN: begin
				if (!busy_all) begin
					state_n = S_IDLE;
				end
			end
			S_READ: begin
				if (out_free) begin
					op_n.valid = 1'b1;
					op_n.kind  = K_READ;
					op_n.oob   = !(32'(idx_q) < 32'(CELLS));
					m_n        = idx_addr;
					old_n      = idx_addr;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// state and issue register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			op_q    <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			op_q    <= op_n;
		end
	end

	// addresses and latched request
	always_ff @(posedge clk) begin
		m_q   <= m_n;
		nb_q  <= nb_n;
		old_q <= old_n;
		if (accept) begin
			gauss_q <= gauss_value;
			sine_q  <= sine_value;
			idx_q   <= cell_index;
		end
	end

	assign ready    = (state_q == S_IDLE);
	assign op       = op_q;
	assign m_addr   = m_q;
	assign nb_addr  = nb_q;
	assign old_addr = old_q;
	assign gauss    = gauss_q;
	assign sine     = sine_q;
endmodule

### rtl/fdtd_1d_yee_field_update_top.sv
// channel | dir | payload                                       | handshake
// item    | in  | opcode, gauss_value, sine_value, cell_index   | valid/ready
// result  | out | e_sample, h_sample                            | valid/ready
// wr      | in  | wr_index, wr_data                             | wr_en
//
// tick request: one cell per cycle through the field memories,
//   h sweep then e sweep, with a pipeline drain after each
// read request: result registered after the memory read, then held until ready
// after reset a clearing pass zeroes every cell of both memories; item.ready stays low
// a read request waits to issue while the result register is full and not taken,
//   or while the previous read result is still on its way
module fdtd_1d_yee_field_update_top #(
	parameter int CELLS = fdtd_pkg::CELLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fdtd_in_if.sink                        item,
	fdtd_out_if.source                     result,
	input  logic                           wr_en,
	input  logic [fdtd_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [fdtd_pkg::COEF_W-1:0]    wr_data
);
	import fdtd_pkg::*;

	localparam int AW = $clog2(CELLS);

	coef_t            e_coef_q, h_coef_q;
	logic [IDX_W-1:0] source_cell_q;

	logic          accept, out_free, core_busy, upd_busy, res_valid, seq_ready;
	issue_t        op;
	logic [AW-1:0] m_addr, nb_addr, old_addr;
	val_t          gauss, sine, res_e, res_h;

	logic out_valid_q;
	val_t e_q, h_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_coef_q      <= E_COEF_RST;
			h_coef_q      <= H_COEF_RST;
			source_cell_q <= SOURCE_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_E_COEF: e_coef_q      <= wr_data;
				REG_H_COEF: h_coef_q      <= wr_data;
				REG_SOURCE: source_cell_q <= wr_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept     = item.valid && seq_ready;
	assign item.ready = seq_ready;
	assign out_free   = (!out_valid_q || result.ready) && !res_valid;

	fdtd_seq #(.CELLS(CELLS)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.opcode      (item.opcode),
		.gauss_value (item.gauss_value),
		.sine_value  (item.sine_value),
		.cell_index  (item.cell_index),
		.source_cell (source_cell_q),
		.out_free    (out_free),
		.core_busy   (core_busy),
		.ready       (seq_ready),
		.op          (op),
		.m_addr      (m_addr),
		.nb_addr     (nb_addr),
		.old_addr    (old_addr),
		.gauss       (gauss),
		.sine        (sine)
	);

	fdtd_core #(.CELLS(CELLS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.m_addr    (m_addr),
		.nb_addr   (nb_addr),
		.old_addr  (old_addr),
		.gauss     (gauss),
		.sine      (sine),
		.e_coef    (e_coef_q),
		.h_coef    (h_coef_q),
		.res_valid (res_valid),
		.res_e     (res_e),
		.res_h     (res_h),
		.busy      (core_busy),
		.upd_busy  (upd_busy)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			e_q <= res_e;
			h_q <= res_h;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.e_sample = e_q;
	assign result.h_sample = h_q;

`ifndef SYNTHESIS
	// a read result never lands on an unconsumed one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || result.ready))
		else $error("result register overwritten");

	// no new request while cell updates are still in the pipeline
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !upd_busy)
		else $error("request taken during field update");

	// clearing writes never overlap pipeline activity
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(op.valid && op.clear) |-> !core_busy)
		else $error("clearing pass overlaps pipeline");
`endif
endmodule
